/* hw/rtl/bbo_pkg.sv */
// ----------------------------------------------------------------------------
// bbo_pkg: shared types and constants
// Field structs, command and status codes, and the controller/datapath link.
// ----------------------------------------------------------------------------
package bbo_pkg;

  localparam int unsigned Symbols  = 16;
  localparam int unsigned Venues   = 4;
  localparam int unsigned SymW     = $clog2(Symbols);
  localparam int unsigned VenW     = $clog2(Venues);
  localparam int unsigned EntW     = SymW + VenW;
  localparam int unsigned Entries  = Symbols * Venues;

  localparam logic [1:0] CmdLoad  = 2'd0;
  localparam logic [1:0] CmdQuote = 2'd1;
  localparam logic [1:0] CmdTick  = 2'd2;

  localparam logic [1:0] StatOk     = 2'd0;
  localparam logic [1:0] StatNoSym  = 2'd1;
  localparam logic [1:0] StatNoVen  = 2'd2;

  localparam logic [2:0] RegVenue0   = 3'd0;
  localparam logic [2:0] RegVenue3   = 3'd3;
  localparam logic [2:0] RegTimeout  = 3'd4;
  localparam logic [2:0] RegSymCount = 3'd5;

  localparam logic [31:0] InitAsk  = 32'hFFFF_FFFF;
  localparam logic [31:0] InitSize = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]         command;
    logic [3:0]         slot;
    logic [63:0]        symbol;
    logic [15:0]        bid_venue;
    logic [15:0]        ask_venue;
    logic [31:0]        bid_px;
    logic signed [31:0] bid_qty;
    logic [31:0]        ask_px;
    logic signed [31:0] ask_qty;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [63:0]        best_symbol;
    logic [15:0]        best_bid_venue;
    logic [31:0]        best_bid_px;
    logic signed [31:0] best_bid_qty;
    logic [15:0]        best_ask_venue;
    logic [31:0]        best_ask_px;
    logic signed [31:0] best_ask_qty;
    logic [31:0]        sequence_res;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;   // latch input beat
    logic lookup;    // symbol/venue match, register hit info
    logic update;    // write quote entry
    logic read;      // register one venue entry at scan_idx
    logic scan;      // stale check and compare on the registered entry
    logic finish;    // load result register
    logic [VenW-1:0] scan_idx;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_quote;
    logic hit;
  } dp_stat_t;

endpackage

/* hw/rtl/bbo_ctrl.sv */
// ----------------------------------------------------------------------------
// bbo_ctrl: command sequencer
// Capture and decode; a quote adds lookup, update, per-venue scan, result.
// ----------------------------------------------------------------------------
module bbo_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               out_busy_i,
  input  bbo_pkg::dp_stat_t  stat_i,
  output bbo_pkg::dp_cmd_t   cmd_o
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StDecode = 3'd1;
  localparam logic [2:0] StLookup = 3'd2;
  localparam logic [2:0] StPrime  = 3'd3;
  localparam logic [2:0] StScan   = 3'd4;
  localparam logic [2:0] StTail   = 3'd5;
  localparam logic [2:0] StDone   = 3'd6;

  localparam logic [bbo_pkg::VenW-1:0] LastVen = bbo_pkg::VenW'(bbo_pkg::Venues - 1);

  logic [2:0] state_q, state_d;
  logic [bbo_pkg::VenW-1:0] idx_q, idx_d;

  assign in_stall_o = (state_q != StIdle);

  // Sequence states
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cmd_o   = '0;
    cmd_o.scan_idx = idx_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = StDecode;
        end
      end
      StDecode: begin
        // load and tick finish here
        if (stat_i.is_quote) begin
          cmd_o.lookup = 1'b1;
          state_d = StLookup;
        end else begin
          state_d = StIdle;
        end
      end
      StLookup: begin
        if (stat_i.hit) begin
          cmd_o.update = 1'b1;
          idx_d = '0;
          state_d = StPrime;
        end else begin
          state_d = StDone;
        end
      end
      // read one entry ahead of the compare
      StPrime, StScan: begin
        cmd_o.read = 1'b1;
        cmd_o.scan = (state_q == StScan);
        if (idx_q == LastVen) begin
          state_d = StTail;
        end else begin
          idx_d = idx_q + 1'b1;
          state_d = StScan;
        end
      end
      StTail: begin
        cmd_o.scan = 1'b1;
        state_d = StDone;
      end
      StDone: begin
        if (!out_busy_i) begin
          cmd_o.finish = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

/* hw/rtl/bbo_datapath.sv */
// ----------------------------------------------------------------------------
// bbo_datapath: symbol table, venue quote store, best-price compare
// Holds config, clock, sequence count and result register.
// ----------------------------------------------------------------------------
module bbo_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bbo_pkg::in_item_t    in_data_i,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [15:0]          cfg_data_i,
  input  bbo_pkg::dp_cmd_t     cmd_i,
  output bbo_pkg::dp_stat_t    stat_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output bbo_pkg::out_item_t   out_data_o
);

  localparam int unsigned SymW = bbo_pkg::SymW;
  localparam int unsigned VenW = bbo_pkg::VenW;
  localparam int unsigned EntW = bbo_pkg::EntW;

  // Configuration
  logic [15:0] venue_id_q [4];
  logic [15:0] timeout_q;
  logic [4:0]  sym_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) venue_id_q[i] <= '0;
      timeout_q   <= 16'd1000;
      sym_count_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i <= bbo_pkg::RegVenue3) venue_id_q[cfg_idx_i[1:0]] <= cfg_data_i;
      else if (cfg_idx_i == bbo_pkg::RegTimeout) timeout_q <= cfg_data_i;
      else if (cfg_idx_i == bbo_pkg::RegSymCount) sym_count_q <= cfg_data_i[4:0];
    end
  end

  // Captured beat
  bbo_pkg::in_item_t item_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) item_q <= in_data_i;
  end

  assign stat_o.is_quote = (item_q.command == bbo_pkg::CmdQuote);

  // Symbol table in flops (16 entries, compared in parallel)
  logic [63:0] sym_tab_q [bbo_pkg::Symbols];
  logic        decode_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) decode_q <= 1'b0;
    else         decode_q <= cmd_i.capture;
  end
  always_ff @(posedge clk_i) begin
    if (decode_q && item_q.command == bbo_pkg::CmdLoad)
      sym_tab_q[item_q.slot[SymW-1:0]] <= item_q.symbol;
  end

  // Millisecond clock
  logic [31:0] now_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) now_q <= '0;
    else if (decode_q && item_q.command == bbo_pkg::CmdTick) now_q <= now_q + 1'b1;
  end

  // Symbol and venue match, lowest first
  logic            sym_hit, ven_hit;
  logic [SymW-1:0] sym_sel;
  logic [VenW-1:0] ven_sel;
  always_comb begin
    sym_hit = 1'b0;
    sym_sel = '0;
    for (int i = bbo_pkg::Symbols - 1; i >= 0; i--) begin
      if (5'(i) < sym_count_q && sym_tab_q[i] == item_q.symbol) begin
        sym_hit = 1'b1;
        sym_sel = SymW'(i);
      end
    end
    ven_hit = 1'b0;
    ven_sel = '0;
    for (int j = bbo_pkg::Venues - 1; j >= 0; j--) begin
      if (venue_id_q[j] != '0 && venue_id_q[j] == item_q.bid_venue &&
          venue_id_q[j] == item_q.ask_venue) begin
        ven_hit = 1'b1;
        ven_sel = VenW'(j);
      end
    end
  end

  logic            hit_q;
  logic [1:0]      err_q;
  logic [SymW-1:0] sym_q;
  logic [VenW-1:0] ven_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      hit_q <= sym_hit && ven_hit;
      err_q <= !sym_hit ? bbo_pkg::StatNoSym :
               (!ven_hit ? bbo_pkg::StatNoVen : bbo_pkg::StatOk);
      sym_q <= sym_sel;
      ven_q <= ven_sel;
    end
  end
  assign stat_o.hit = hit_q;

  // Quote store: valid bit per entry, invalid reads as the reset quote
  logic [31:0] bp_q [bbo_pkg::Entries];
  logic [31:0] ap_q [bbo_pkg::Entries];
  logic [31:0] bs_q [bbo_pkg::Entries];
  logic [31:0] as_q [bbo_pkg::Entries];
  logic [31:0] tu_q [bbo_pkg::Entries];
  logic [bbo_pkg::Entries-1:0] vld_q;
  logic [bbo_pkg::Entries-1:0] live_q; // quote not cleared since last write

  logic [EntW-1:0] wr_ent, rd_ent, ev_ent;
  assign wr_ent = {sym_q, ven_q};
  assign rd_ent = {sym_q, cmd_i.scan_idx};

  // Register one venue entry; update and reads never overlap
  logic [31:0]     rd_bp_q, rd_ap_q, rd_bs_q, rd_as_q, rd_tu_q;
  logic            rd_vld_q, rd_live_q;
  logic [VenW-1:0] rd_idx_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      rd_bp_q   <= bp_q[rd_ent];
      rd_ap_q   <= ap_q[rd_ent];
      rd_bs_q   <= bs_q[rd_ent];
      rd_as_q   <= as_q[rd_ent];
      rd_tu_q   <= tu_q[rd_ent];
      rd_vld_q  <= vld_q[rd_ent];
      rd_live_q <= live_q[rd_ent];
      rd_idx_q  <= cmd_i.scan_idx;
    end
  end
  assign ev_ent = {sym_q, rd_idx_q};

  logic [31:0] r_bp, r_ap, r_bs, r_as, r_tu, age;
  logic        stale, scan_first;
  logic [15:0] r_id;
  always_comb begin
    r_tu = rd_vld_q ? rd_tu_q : '0;
    if (rd_vld_q && rd_live_q) begin
      r_bp = rd_bp_q;
      r_ap = rd_ap_q;
      r_bs = rd_bs_q;
      r_as = rd_as_q;
    end else begin
      r_bp = '0;
      r_ap = bbo_pkg::InitAsk;
      r_bs = bbo_pkg::InitSize;
      r_as = bbo_pkg::InitSize;
    end
    r_id  = venue_id_q[rd_idx_q];
    age   = now_q - r_tu;
    stale = (r_id != '0) && (age > {16'd0, timeout_q});
    if (stale) begin
      r_bp = '0;
      r_ap = bbo_pkg::InitAsk;
      r_bs = bbo_pkg::InitSize;
      r_as = bbo_pkg::InitSize;
    end
  end
  assign scan_first = (rd_idx_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      live_q <= '0;
    end else if (cmd_i.update) begin
      vld_q[wr_ent]  <= 1'b1;
      live_q[wr_ent] <= 1'b1;
    end else if (cmd_i.scan && stale) begin
      live_q[ev_ent] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      bp_q[wr_ent] <= item_q.bid_px;
      ap_q[wr_ent] <= item_q.ask_px;
      bs_q[wr_ent] <= item_q.bid_qty;
      as_q[wr_ent] <= item_q.ask_qty;
      tu_q[wr_ent] <= now_q;
    end
  end

  // Running best over venues
  logic [15:0] bbv_q, bav_q;
  logic [31:0] bbp_q, bbs_q, bap_q, bas_q;
  logic [15:0] cbv, cav;
  logic [31:0] cbp, cbs, cap, cas;
  always_comb begin
    cbv = scan_first ? 16'd0 : bbv_q;
    cbp = scan_first ? 32'd0 : bbp_q;
    cbs = scan_first ? bbo_pkg::InitSize : bbs_q;
    cav = scan_first ? 16'd0 : bav_q;
    cap = scan_first ? bbo_pkg::InitAsk : bap_q;
    cas = scan_first ? bbo_pkg::InitSize : bas_q;
    if (r_bp > cbp) begin
      cbp = r_bp; cbv = r_id; cbs = r_bs;
    end
    if (r_ap < cap) begin
      cap = r_ap; cav = r_id; cas = r_as;
    end
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan) begin
      bbv_q <= cbv; bbp_q <= cbp; bbs_q <= cbs;
      bav_q <= cav; bap_q <= cap; bas_q <= cas;
    end
  end

  // Result register and sequence count
  logic [31:0] seq_q;
  logic        ov_q, ov_d;
  bbo_pkg::out_item_t od_q, od_d;

  always_comb begin
    ov_d = ov_q;
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    if (cmd_i.finish) ov_d = 1'b1;
  end

  always_comb begin
    od_d = '0;
    od_d.best_symbol = item_q.symbol;
    od_d.status      = err_q;
    if (hit_q) begin
      od_d.best_bid_venue = bbv_q;
      od_d.best_bid_px    = bbp_q;
      od_d.best_bid_qty   = bbs_q;
      od_d.best_ask_venue = bav_q;
      od_d.best_ask_px    = bap_q;
      od_d.best_ask_qty   = bas_q;
      od_d.sequence_res   = seq_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q  <= 1'b0;
      seq_q <= '0;
    end else begin
      ov_q <= ov_d;
      if (cmd_i.finish && hit_q) seq_q <= seq_q + 1'b1;
    end
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) od_q <= od_d;
  end
  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

endmodule

/* hw/rtl/best_bid_offer_aggregator_top.sv */
// ----------------------------------------------------------------------------
// best_bid_offer_aggregator_top: consolidated best bid/offer
// Symbol lookup, per-venue quote store and best bid/ask selection.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake     | payload
//  in       | input     | valid / stall | bbo_pkg::in_item_t
//  out      | output    | valid / stall | bbo_pkg::out_item_t
//  cfg      | input     | valid / ready | index (3b), data (16b)
//
// Load, tick and unknown commands pass through accept and decode; a quote that
// misses passes through accept, decode, lookup and result; a quote that hits
// also writes its entry in lookup, reads one venue entry ahead, then compares
// every venue over the registered quote store reads. A finished result waits in
// the output register; a stalled result delays only the result step of the next
// quote. Reset clears all quote entries at once via valid bits.
module best_bid_offer_aggregator_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bbo_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bbo_pkg::out_item_t  out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i
);

  bbo_pkg::dp_cmd_t  cmd;
  bbo_pkg::dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  bbo_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_busy_i (out_valid_o && out_stall_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bbo_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i),
    .cfg_idx_i   (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* hw/rtl/bbo_checker.sv */
// ----------------------------------------------------------------------------
// bbo_checker: port-level properties
// Watches handshakes and result fields of the top level.
// ----------------------------------------------------------------------------
module bbo_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input bbo_pkg::out_item_t out_data_o
);

  // hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // error results carry no bid price and no sequence number
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != bbo_pkg::StatOk |->
      out_data_o.best_bid_px == '0 && out_data_o.sequence_res == '0)
    else $error("error result not cleared");

  // a beat taken stalls the input next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after beat");

  // empty bid side pairs with venue zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.best_bid_px == '0 |->
      out_data_o.best_bid_venue == '0)
    else $error("bid venue without price");

endmodule

bind best_bid_offer_aggregator_top bbo_checker u_bbo_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
